/* src/lkvc_pkg.sv */
package lkvc_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned KEY_BITS   = 16;
  localparam int unsigned VALUE_BITS = 16;

  localparam int unsigned RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);

  // capacity register, fixed 5-bit field at register index 0
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic [APB_ADDR_W-1:0] ADDR_CAPACITY = APB_ADDR_W'(0);

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [RANK_W-1:0]     rank_t;
  typedef logic [CNT_W-1:0]      count_t;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  typedef struct packed {
    op_e    op;
    key_t   key;
    value_t value;
  } req_t;

  typedef struct packed {
    logic   found;
    value_t read_value;
    logic   evicted;
    key_t   evicted_key;
  } rsp_t;

endpackage

/* src/lru_key_value_cache.sv */
// fully associative key-value cache with least-recently-used replacement
// slave stream: one beat per get or put, tuser carries the op (0 get, 1 put),
//   tdata carries key and value
// master stream: one result beat per request beat, tuser carries found and
//   evicted, tdata carries read_value and evicted_key (zero when not valid)
// apb port: register 0 is capacity_in_use (5 bits, reset 16); 0 acts as 1,
//   anything above the entry count acts as the entry count
// a request beat lands in the input register, is looked up and applied to
//   the store once the result register is free or draining, and its result
//   beat is then offered on the master side from the result register;
//   one beat per cycle sustained while the master side takes every result
//   beat, the rate is set by the parallel key compare and rank update over all entries
// a stalled master side holds the result register, the input register then
//   fills and s_axis_tready drops; nothing is lost or repeated
// reset empties the cache (all entries invalid, occupancy zero) and sets the
//   capacity to its full value; no clearing pass is needed
module lru_key_value_cache (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] key, [31:16] value
  input  logic        s_axis_tuser,   // [0] op
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] read_value, [31:16] evicted_key
  output logic [1:0]  m_axis_tuser,   // [0] found, [1] evicted
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [lkvc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lkvc_pkg::*;

  logic             in_valid_q;
  req_t             in_req_q;
  logic             out_valid_q;
  rsp_t             out_rsp_q;
  rsp_t             rsp;
  logic             fire;
  logic [CAP_W-1:0] cap_q;

  // apb register, written on the access phase
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY)) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_CAPACITY) ? 32'(cap_q) : '0;

  // store stage fires when a request waits and the result slot is free or draining
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req_q.op    <= op_e'(s_axis_tuser);
      in_req_q.key   <= s_axis_tdata[KEY_BITS-1:0];
      in_req_q.value <= s_axis_tdata[16 +: VALUE_BITS];
    end
  end

  // lookup and update of the entry array
  lkvc_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .req_i      (in_req_q),
    .capacity_i (cap_q),
    .rsp_o      (rsp)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_rsp_q <= rsp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {16'(out_rsp_q.evicted_key), 16'(out_rsp_q.read_value)};
  assign m_axis_tuser  = {out_rsp_q.evicted, out_rsp_q.found};

endmodule

/* src/lkvc_store.sv */
module lkvc_store (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  lkvc_pkg::req_t        req_i,
  input  logic [lkvc_pkg::CAP_W-1:0] capacity_i,
  output lkvc_pkg::rsp_t        rsp_o
);
  import lkvc_pkg::*;

  localparam int unsigned CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  key_t              key_q   [ENTRIES];
  value_t            value_q [ENTRIES];
  rank_t             rank_q  [ENTRIES];
  rank_t             rank_d  [ENTRIES];
  logic [ENTRIES-1:0] valid_q, valid_d;
  count_t            occ_q, occ_d;

  logic [ENTRIES-1:0] hit_vec, lru_vec, free_vec, invalid_vec, touch_vec;
  logic               hit, evict, fill, is_put;
  rank_t              hit_rank, lru_rank;
  value_t             hit_value;
  key_t               lru_key;
  count_t             limit;
  logic [CMP_W-1:0]   eff_cap, occ_ext;

  // parallel key compare, lru is the valid entry holding the oldest rank
  always_comb begin
    lru_rank  = rank_t'(occ_q - count_t'(1));
    hit_rank  = '0;
    hit_value = '0;
    lru_key   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_q[i] && (key_q[i] == req_i.key);
      lru_vec[i] = valid_q[i] && (rank_q[i] == lru_rank);
      hit_rank   = hit_rank  | (hit_vec[i] ? rank_q[i]  : '0);
      hit_value  = hit_value | (hit_vec[i] ? value_q[i] : '0);
      lru_key    = lru_key   | (lru_vec[i] ? key_q[i]   : '0);
    end
  end

  assign invalid_vec = ~valid_q;
  assign free_vec    = invalid_vec & ~(invalid_vec - ENTRIES'(1));

  always_comb begin
    if (capacity_i == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity_i) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(capacity_i);
    end
  end

  assign occ_ext = CMP_W'(occ_q);
  assign hit     = |hit_vec;
  assign is_put  = (req_i.op == OP_PUT);
  assign evict   = is_put && !hit && (occ_ext >= eff_cap);
  assign fill    = is_put && !hit && !evict && (|invalid_vec);

  always_comb begin
    if (hit) begin
      touch_vec = hit_vec;
      limit     = count_t'(hit_rank);
    end else if (evict) begin
      touch_vec = lru_vec;
      limit     = count_t'(lru_rank);
    end else if (fill) begin
      touch_vec = free_vec;
      limit     = count_t'(ENTRIES);
    end else begin
      touch_vec = '0;
      limit     = '0;
    end
  end

  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
      if (touch_vec[i]) begin
        rank_d[i] = '0;
      end else if (valid_q[i] && (count_t'(rank_q[i]) < limit)) begin
        rank_d[i] = rank_q[i] + rank_t'(1);
      end
    end
    if (fill) begin
      valid_d = valid_q | free_vec;
      occ_d   = occ_q + count_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (fire_i) begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (fire_i && is_put && touch_vec[i]) begin
        key_q[i]   <= req_i.key;
        value_q[i] <= req_i.value;
      end
    end
  end

  always_comb begin
    rsp_o.found       = hit;
    rsp_o.read_value  = (hit && !is_put) ? hit_value : '0;
    rsp_o.evicted     = evict;
    rsp_o.evicted_key = evict ? lru_key : '0;
  end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lkvc_pkg::*;

  localparam int unsigned MAX_IDLE       = 19;
  localparam int unsigned RAND_PER_PHASE = 148;

  // one row of the directed table; typed rows carry their result inline
  typedef struct {
    op_e    op;
    key_t   key;
    value_t value;
    bit     typed;
    rsp_t   want;
  } stim_row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata  = '0;   // [15:0] key, [31:16] value
  logic                  s_axis_tuser  = 1'b0; // [0] op
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;         // [15:0] read_value, [31:16] evicted_key
  logic [1:0]            m_axis_tuser;         // [0] found, [1] evicted
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [31:0]           pwdata        = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // typed expectation that travels with the beat currently offered
  bit   stim_typed = 1'b0;
  rsp_t stim_want  = '0;

  // results owed by the block, oldest first
  rsp_t due_results[$];
  int   bad_beats = 0;

  // idle pattern state: stretches of calm (no idling) mix at random with busy ones
  int src_left  = 0;
  bit src_calm  = 1'b0;
  int sink_left = 0;
  bit sink_calm = 1'b0;

  // shadow of the cache contents and the capacity register
  key_t             slot_key  [ENTRIES];
  value_t           slot_val  [ENTRIES];
  bit               slot_used [ENTRIES];
  int unsigned      slot_age  [ENTRIES];
  int unsigned      fill_count = 0;
  logic [CAP_W-1:0] cap_reg    = CAP_RESET;

  always #4 clk_i = ~clk_i;

  lru_key_value_cache dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  function automatic rsp_t reply(logic f, value_t rv, logic e, key_t ek);
    rsp_t r;
    r.found       = f;
    r.read_value  = rv;
    r.evicted     = e;
    r.evicted_key = ek;
    return r;
  endfunction

  // entries younger than limit age by one, the touched slot becomes newest
  function automatic void make_newest(int slot, int unsigned limit);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && i != slot && slot_age[i] < limit) slot_age[i]++;
    end
    slot_age[slot] = 0;
  endfunction

  // applies one get or put to the shadow cache and returns its result beat
  function automatic rsp_t lru_access(op_e op, key_t k, value_t v);
    rsp_t        r;
    int          hit;
    int          slot;
    int unsigned oldest;
    int unsigned limit_cap;
    r      = '0;
    hit    = -1;
    slot   = -1;
    oldest = 0;
    // zero behaves as one, anything past the entry count as the entry count
    limit_cap = (cap_reg == 0) ? 1 : (cap_reg > ENTRIES) ? ENTRIES : cap_reg;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && slot_used[i] && slot_key[i] == k) hit = i;
    end
    if (hit >= 0) begin
      r.found = 1'b1;
      if (op == OP_GET) r.read_value = slot_val[hit];
      else slot_val[hit] = v;
      make_newest(hit, slot_age[hit]);
    end else if (op == OP_PUT) begin
      if (fill_count >= limit_cap) begin
        // full (or capacity lowered under occupancy): replace the oldest in place
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_used[i] && (slot < 0 || slot_age[i] >= oldest)) begin
            slot   = i;
            oldest = slot_age[i];
          end
        end
        if (slot >= 0) begin
          r.evicted      = 1'b1;
          r.evicted_key  = slot_key[slot];
          slot_key[slot] = k;
          slot_val[slot] = v;
          make_newest(slot, oldest);
        end
      end else begin
        // room left: take the lowest free slot
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && !slot_used[i]) slot = i;
        end
        make_newest(slot, ENTRIES);
        slot_used[slot] = 1'b1;
        slot_key[slot]  = k;
        slot_val[slot]  = v;
        fill_count++;
      end
    end
    return r;
  endfunction

  function automatic void flag_beat(string what, rsp_t want, rsp_t got);
    if (bad_beats < 10)
      $display("%0t %s: want found=%0b read=%h evicted=%0b key=%h",
               $realtime, what, want.found, want.read_value, want.evicted,
               want.evicted_key);
    if (bad_beats < 10)
      $display("    got  found=%0b read=%h evicted=%0b key=%h",
               got.found, got.read_value, got.evicted, got.evicted_key);
    bad_beats++;
  endfunction

  // cycles to hold off before the next beat; calm stretches hold off nothing
  function automatic int pause_len(inout int left, inout bit calm);
    if (left == 0) begin
      left = $urandom_range(8, 60);
      calm = ($urandom_range(0, 3) == 0);
    end
    left--;
    return calm ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // all sampling at the rising edge: results are checked first, since a
  // result can never belong to a request accepted at the same edge
  always @(posedge clk_i) begin : scoreboard
    rsp_t got;
    rsp_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = reply(m_axis_tuser[0], m_axis_tdata[15:0], m_axis_tuser[1],
                  m_axis_tdata[31:16]);
      if (due_results.size() == 0) begin
        flag_beat("result beat with nothing pending", '0, got);
      end else begin
        want = due_results.pop_front();
        if (got.found !== want.found || got.read_value !== want.read_value ||
            got.evicted !== want.evicted || got.evicted_key !== want.evicted_key)
          flag_beat("result mismatch", want, got);
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      // the shadow cache always advances, typed rows override its answer
      want = lru_access(op_e'(s_axis_tuser), s_axis_tdata[15:0], s_axis_tdata[31:16]);
      due_results.push_back(stim_typed ? stim_want : want);
    end
    if (psel && penable && pwrite && pready && paddr == ADDR_CAPACITY)
      cap_reg = pwdata[CAP_W-1:0];
  end

  // called at a falling edge, returns at the falling edge after acceptance;
  // valid stays high across back-to-back beats
  task automatic send_item(op_e op, key_t k, value_t v, bit typed, rsp_t want);
    int gap;
    gap = pause_len(src_left, src_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {v, k};
    stim_typed    <= typed;
    stim_want     <= want;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk_i);
  endtask

  // stop offering beats and let every owed result come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic write_capacity(logic [CAP_W-1:0] c);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_CAPACITY;
    pwdata  <= 32'(c);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // result side: random back-pressure per beat, with calm stretches
  initial begin : sink
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = pause_len(sink_left, sink_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    stim_row_t        rows[$];
    logic [CAP_W-1:0] caps[$];
    key_t             pool[$];
    int unsigned      eff;
    int unsigned      pick;
    key_t             k;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part at reset capacity (full size)
    // gets on an empty cache miss with all fields zero
    rows.push_back('{OP_GET, 16'h0000, 16'h5a5a, 1'b1, reply(1'b0, '0, 1'b0, '0)});
    rows.push_back('{OP_GET, 16'hffff, 16'ha5a5, 1'b1, reply(1'b0, '0, 1'b0, '0)});
    // extreme keys and values go in, both misses with free room
    rows.push_back('{OP_PUT, 16'h0000, 16'hffff, 1'b1, reply(1'b0, '0, 1'b0, '0)});
    rows.push_back('{OP_PUT, 16'hffff, 16'h0000, 1'b1, reply(1'b0, '0, 1'b0, '0)});
    // get hits return the stored values
    rows.push_back('{OP_GET, 16'h0000, 16'h0000, 1'b1, reply(1'b1, 16'hffff, 1'b0, '0)});
    rows.push_back('{OP_GET, 16'hffff, 16'hffff, 1'b1, reply(1'b1, 16'h0000, 1'b0, '0)});
    // put hit: found only, value overwritten
    rows.push_back('{OP_PUT, 16'h0000, 16'h1234, 1'b1, reply(1'b1, '0, 1'b0, '0)});
    rows.push_back('{OP_GET, 16'h0000, 16'h0000, 1'b0, '0});
    // fill the remaining fourteen slots
    for (int i = 1; i <= 14; i++)
      rows.push_back('{OP_PUT, key_t'(i * 16'h0111), value_t'($urandom), 1'b0, '0});
    // full cache: the oldest key (all ones) is evicted
    rows.push_back('{OP_PUT, 16'h8000, 16'ha5a5, 1'b1, reply(1'b0, '0, 1'b1, 16'hffff)});
    rows.push_back('{OP_GET, 16'hffff, 16'h0000, 1'b1, reply(1'b0, '0, 1'b0, '0)});
    rows.push_back('{OP_GET, 16'h8000, 16'h0000, 1'b0, '0});

    foreach (rows[i]) send_item(rows[i].op, rows[i].key, rows[i].value, rows[i].typed,
                                rows[i].want);
    drain();

    // random phases over capacity settings; zero and values past the entry
    // count included, and several drops below current occupancy
    caps = '{5'd0, 5'd1, 5'd31, 5'd3, 5'd16, 5'd7, 5'd17, 5'd2, 5'd12};
    caps.push_back(CAP_W'($urandom_range(0, 31)));
    caps.push_back(CAP_W'($urandom_range(0, 31)));

    foreach (caps[p]) begin
      write_capacity(caps[p]);
      eff = (caps[p] == 0) ? 1 : (caps[p] > ENTRIES) ? ENTRIES : caps[p];
      // key pool a bit larger than the capacity keeps hits and evictions common
      pool.delete();
      repeat (eff + $urandom_range(0, 8)) pool.push_back(key_t'($urandom));
      repeat (RAND_PER_PHASE) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) k = $urandom_range(0, 1) ? key_t'('1) : key_t'(0);
        else if (pick == 1) k = key_t'($urandom);
        else k = pool[$urandom_range(0, pool.size() - 1)];
        send_item(op_e'($urandom_range(0, 1)), k, value_t'($urandom), 1'b0, '0);
      end
      // sender holds off until everything owed has come back
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (due_results.size() != 0) bad_beats += due_results.size();
    if (bad_beats == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit, well above the slowest legal run
  initial begin : watchdog
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
